### rtl/cfc_pkg.sv
`default_nettype none
package cfc_pkg;

  localparam logic [31:0] CRC_POLY = 32'hEDB88320;
  localparam logic [31:0] CRC_ONES = 32'hFFFFFFFF;
  localparam logic [31:0] SYNC_RESET = 32'h48415400;
  localparam int unsigned MAXLEN_W = 25;
  localparam logic [MAXLEN_W-1:0] MAXLEN_RESET = 25'd65536;
  localparam int unsigned CNT_W = 25;
  localparam int unsigned ADDR_W = 3;

  typedef enum logic [0:0] {
    REG_SYNC   = 1'b0,
    REG_MAXLEN = 1'b1
  } cfc_reg_t;

  typedef enum logic [2:0] {
    ST_OK    = 3'd0,
    ST_SYNC  = 3'd1,
    ST_CRC   = 3'd2,
    ST_LEN   = 3'd3,
    ST_TRUNC = 3'd4
  } cfc_status_t;

  typedef struct packed {
    logic [7:0] rx_byte;
    logic       frame_start;
  } cfc_in_t;

  typedef struct packed {
    logic        kind;
    logic [7:0]  payload_byte;
    logic [2:0]  status;
    logic [15:0] seq_number;
    logic [31:0] frame_len;
  } cfc_out_t;

  typedef struct packed {
    logic [31:0]         sync_pattern;
    logic [MAXLEN_W-1:0] max_payload_len;
  } cfc_cfg_t;

  // Reflected CRC-32 update over one byte, one bit per step.
  function automatic logic [31:0] crc32_byte(input logic [31:0] crc, input logic [7:0] b);
    logic [31:0] c;
    c = crc ^ {24'd0, b};
    for (int k = 0; k < 8; k++) begin
      c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
    end
    return c;
  endfunction

endpackage
`default_nettype wire

### rtl/cfc_cfg_regs.sv
`default_nettype none
module cfc_cfg_regs (
  input  wire logic                      clk,
  input  wire logic                      rst_n,
  input  wire logic                      psel,
  input  wire logic                      penable,
  input  wire logic                      pwrite,
  input  wire logic [cfc_pkg::ADDR_W-1:0] paddr,
  input  wire logic [31:0]               pwdata,
  output logic      [31:0]               prdata,
  output logic                           pready,
  output cfc_pkg::cfc_cfg_t              cfg
);
  import cfc_pkg::*;

  logic [31:0]         sync_r;
  logic [MAXLEN_W-1:0] maxlen_r;
  logic                wr_en;
  cfc_reg_t            sel;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite;
  assign sel    = cfc_reg_t'(paddr[2]);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sync_r   <= SYNC_RESET;
      maxlen_r <= MAXLEN_RESET;
    end else if (wr_en) begin
      unique case (sel)
        REG_SYNC:   sync_r   <= pwdata;
        REG_MAXLEN: maxlen_r <= pwdata[MAXLEN_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (sel)
      REG_SYNC:   prdata = sync_r;
      REG_MAXLEN: prdata = {{(32-MAXLEN_W){1'b0}}, maxlen_r};
      default:    prdata = 32'd0;
    endcase
  end

  assign cfg.sync_pattern    = sync_r;
  assign cfg.max_payload_len = maxlen_r;

endmodule
`default_nettype wire

### rtl/cfc_parser.sv
`default_nettype none
module cfc_parser (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              step,
  input  wire cfc_pkg::cfc_in_t  item,
  input  wire cfc_pkg::cfc_cfg_t cfg,
  output logic                   res_valid,
  output cfc_pkg::cfc_out_t      res
);
  import cfc_pkg::*;

  typedef enum logic [2:0] {
    PH_IDLE,
    PH_SYNC,
    PH_SEQ,
    PH_LEN,
    PH_PAY,
    PH_CRC
  } phase_t;

  phase_t           phase_r, phase_nxt, ph_w;
  logic [CNT_W-1:0] cnt_r, cnt_nxt, cnt_w, cnt_inc;
  logic [31:0]      crc_r, crc_nxt, crc_w, crc_upd;
  logic [23:0]      sync_r, sync_nxt, sync_w;
  logic [15:0]      seq_r, seq_nxt, seq_w;
  logic [31:0]      len_r, len_nxt, len_w, len_full;
  logic [23:0]      crcsh_r, crcsh_nxt, crcsh_w;
  logic             trunc;
  logic [7:0]       b;
  logic [1:0]       idx;

  function automatic logic [23:0] ins24(input logic [23:0] w, input logic [1:0] i,
                                        input logic [7:0] v);
    logic [23:0] r;
    r = w;
    unique case (i)
      2'd0:    r[7:0]   = v;
      2'd1:    r[15:8]  = v;
      2'd2:    r[23:16] = v;
      default: ;
    endcase
    return r;
  endfunction

  assign b       = item.rx_byte;
  assign idx     = cnt_w[1:0];
  assign cnt_inc = cnt_w + 1'b1;
  assign crc_upd = crc32_byte(crc_w, b);

  always_comb begin
    trunc = 1'b0;
    if (item.frame_start) begin
      // restart: this byte is the first sync byte of a fresh frame
      trunc   = (phase_r != PH_IDLE);
      ph_w    = PH_SYNC;
      cnt_w   = '0;
      crc_w   = CRC_ONES;
      sync_w  = '0;
      seq_w   = '0;
      len_w   = '0;
      crcsh_w = '0;
    end else begin
      ph_w    = phase_r;
      cnt_w   = cnt_r;
      crc_w   = crc_r;
      sync_w  = sync_r;
      seq_w   = seq_r;
      len_w   = len_r;
      crcsh_w = crcsh_r;
    end

    phase_nxt = ph_w;
    cnt_nxt   = cnt_w;
    crc_nxt   = crc_w;
    sync_nxt  = sync_w;
    seq_nxt   = seq_w;
    len_nxt   = len_w;
    crcsh_nxt = crcsh_w;
    len_full  = {b, len_w[23:0]};

    res_valid        = trunc;
    res.kind         = 1'b1;
    res.payload_byte = 8'd0;
    res.status       = ST_TRUNC;

    unique case (ph_w)
      PH_SYNC: begin
        crc_nxt  = crc_upd;
        sync_nxt = ins24(sync_w, idx, b);
        cnt_nxt  = cnt_inc;
        if (idx == 2'd3) begin
          cnt_nxt = '0;
          if ({b, sync_w} != cfg.sync_pattern) begin
            res_valid  = 1'b1;
            res.status = ST_SYNC;
            phase_nxt  = PH_IDLE;
          end else begin
            phase_nxt = PH_SEQ;
          end
        end
      end
      PH_SEQ: begin
        crc_nxt = crc_upd;
        cnt_nxt = cnt_inc;
        if (!cnt_w[0]) begin
          seq_nxt = {seq_w[15:8], b};
        end else begin
          seq_nxt   = {b, seq_w[7:0]};
          cnt_nxt   = '0;
          phase_nxt = PH_LEN;
        end
      end
      PH_LEN: begin
        crc_nxt = crc_upd;
        cnt_nxt = cnt_inc;
        if (idx == 2'd3) begin
          len_nxt = len_full;
          cnt_nxt = '0;
          if (len_full > {{(32-MAXLEN_W){1'b0}}, cfg.max_payload_len}) begin
            res_valid  = 1'b1;
            res.status = ST_LEN;
            phase_nxt  = PH_IDLE;
          end else begin
            phase_nxt = (len_full == 32'd0) ? PH_CRC : PH_PAY;
          end
        end else begin
          len_nxt = {8'd0, ins24(len_w[23:0], idx, b)};
        end
      end
      PH_PAY: begin
        crc_nxt          = crc_upd;
        res_valid        = 1'b1;
        res.kind         = 1'b0;
        res.payload_byte = b;
        res.status       = ST_OK;
        cnt_nxt          = cnt_inc;
        if ({{(32-CNT_W){1'b0}}, cnt_inc} >= len_w) begin
          cnt_nxt   = '0;
          phase_nxt = PH_CRC;
        end
      end
      PH_CRC: begin
        crcsh_nxt = ins24(crcsh_w, idx, b);
        cnt_nxt   = cnt_inc;
        if (idx == 2'd3) begin
          cnt_nxt    = '0;
          res_valid  = 1'b1;
          res.status = ({b, crcsh_w} == ~crc_w) ? ST_OK : ST_CRC;
          phase_nxt  = PH_IDLE;
        end
      end
      default: phase_nxt = PH_IDLE;
    endcase

    // truncated status reports the old frame's fields
    res.seq_number = trunc ? seq_r : seq_nxt;
    res.frame_len  = trunc ? len_r : len_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_IDLE;
      cnt_r   <= '0;
      crc_r   <= CRC_ONES;
      sync_r  <= '0;
      seq_r   <= '0;
      len_r   <= '0;
      crcsh_r <= '0;
    end else if (step) begin
      phase_r <= phase_nxt;
      cnt_r   <= cnt_nxt;
      crc_r   <= crc_nxt;
      sync_r  <= sync_nxt;
      seq_r   <= seq_nxt;
      len_r   <= len_nxt;
      crcsh_r <= crcsh_nxt;
    end
  end

endmodule
`default_nettype wire

### rtl/crc32_frame_checker.sv
`default_nettype none
// Byte-serial frame checker: takes one received byte per cycle unless the output
// stalls, passes payload bytes on as kind 0 results and gives one kind 1 status result
// when a frame ends (ok, sync mismatch, CRC mismatch, length over max_payload_len, or
// truncated by a new frame_start). Each byte is held in an input register, then the
// parser updates its state and byte-wise CRC-32 combinationally and loads the result
// register, so a byte can be accepted on every clock while the result register is not
// stalled. Bytes that produce no result still take their slot, and a stalled result
// register holds the input register and then in_ready. Configuration must be written
// only while no frame data is in flight; the block itself does not enforce this.
module crc32_frame_checker (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire logic                       in_valid,
  output logic                            in_ready,
  input  wire cfc_pkg::cfc_in_t           in_data,
  output logic                            out_valid,
  input  wire logic                       out_ready,
  output cfc_pkg::cfc_out_t               out_data,
  input  wire logic                       psel,
  input  wire logic                       penable,
  input  wire logic                       pwrite,
  input  wire logic [cfc_pkg::ADDR_W-1:0] paddr,
  input  wire logic [31:0]                pwdata,
  output logic      [31:0]                prdata,
  output logic                            pready
);
  import cfc_pkg::*;

  cfc_cfg_t cfg;
  cfc_in_t  s0_data_r;
  logic     s0_valid_r;
  logic     advance;
  logic     res_valid;
  cfc_out_t res;
  logic     out_valid_r;
  cfc_out_t out_data_r;

  cfc_cfg_regs u_regs (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  assign advance  = s0_valid_r && (!out_valid_r || out_ready);
  assign in_ready = !s0_valid_r || advance;

  cfc_parser u_parser (
    .clk       (clk),
    .rst_n     (rst_n),
    .step      (advance),
    .item      (s0_data_r),
    .cfg       (cfg),
    .res_valid (res_valid),
    .res       (res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s0_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (in_valid && in_ready) begin
        s0_valid_r <= 1'b1;
        s0_data_r  <= in_data;
      end else if (advance) begin
        s0_valid_r <= 1'b0;
      end
      if (advance) begin
        out_valid_r <= res_valid;
        out_data_r  <= res;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

`ifndef SYNTHESIS
  a_stall_means_full: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ready |-> (s0_valid_r && out_valid_r && !out_ready))
    else $error("in_ready low without a blocked pipeline");

  a_hold_stage0: assert property (@(posedge clk) disable iff (!rst_n)
    (s0_valid_r && !advance) |=> (s0_valid_r && $stable(s0_data_r)))
    else $error("input register changed while waiting");

  a_payload_ok: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_data_r.kind) |-> (out_data_r.status == ST_OK))
    else $error("payload result carries a status");
`endif

endmodule
`default_nettype wire

### sim/crc32_frame_checker_test.sv
`default_nettype none
module crc32_frame_checker_test;
  timeunit 1ns;
  timeprecision 1ps;

  import cfc_pkg::*;

  localparam int unsigned CYCLE_LIMIT = 500_000;
  localparam logic KIND_BYTE = 1'b0;
  localparam logic KIND_STATUS = 1'b1;

  typedef enum logic [2:0] {
    FR_IDLE,
    FR_SYNC,
    FR_SEQ,
    FR_LEN,
    FR_BODY,
    FR_FCS
  } frame_phase_t;

  // Tracks the deframer: registers, parser state, running CRC and the results still owed.
  class frame_tracker;
    logic [31:0]  sync_cfg;
    logic [24:0]  maxlen_cfg;
    frame_phase_t phase;
    int unsigned  field_cnt;
    logic [31:0]  crc_acc;
    logic [31:0]  sync_word;
    logic [15:0]  seq_word;
    logic [31:0]  len_word;
    logic [31:0]  fcs_word;
    cfc_out_t     awaited[$];
    int           errors;

    function new();
      sync_cfg = SYNC_RESET;
      maxlen_cfg = MAXLEN_RESET;
      phase = FR_IDLE;
      errors = 0;
      restart_frame();
    endfunction

    static function logic [31:0] crc_step(logic [31:0] c, logic [7:0] b);
      logic [31:0] r;
      r = c ^ {24'd0, b};
      for (int k = 0; k < 8; k++) begin
        if (r[0]) r = (r >> 1) ^ CRC_POLY;
        else r = r >> 1;
      end
      return r;
    endfunction

    function void restart_frame();
      field_cnt = 0;
      crc_acc = CRC_ONES;
      sync_word = '0;
      seq_word = '0;
      len_word = '0;
      fcs_word = '0;
    endfunction

    function void set_reg(cfc_reg_t r, logic [31:0] v);
      case (r)
        REG_SYNC: sync_cfg = v;
        REG_MAXLEN: maxlen_cfg = v[24:0];
        default: ;
      endcase
    endfunction

    function void owe(logic kind, logic [7:0] b, cfc_status_t st);
      cfc_out_t e;
      e.kind = kind;
      e.payload_byte = b;
      e.status = st;
      e.seq_number = seq_word;
      e.frame_len = len_word;
      awaited.push_back(e);
    endfunction

    function void absorb_byte(cfc_in_t d);
      logic [7:0] b;
      b = d.rx_byte;
      if (d.frame_start) begin
        if (phase != FR_IDLE) owe(KIND_STATUS, 8'd0, ST_TRUNC);
        phase = FR_SYNC;
        restart_frame();
      end
      case (phase)
        FR_SYNC: begin
          crc_acc = crc_step(crc_acc, b);
          sync_word[8*(field_cnt%4) +: 8] = b;
          field_cnt++;
          if (field_cnt >= 4) begin
            field_cnt = 0;
            if (sync_word != sync_cfg) begin
              owe(KIND_STATUS, 8'd0, ST_SYNC);
              phase = FR_IDLE;
            end else begin
              phase = FR_SEQ;
            end
          end
        end
        FR_SEQ: begin
          crc_acc = crc_step(crc_acc, b);
          seq_word[8*(field_cnt%2) +: 8] = b;
          field_cnt++;
          if (field_cnt >= 2) begin
            field_cnt = 0;
            phase = FR_LEN;
          end
        end
        FR_LEN: begin
          crc_acc = crc_step(crc_acc, b);
          len_word[8*(field_cnt%4) +: 8] = b;
          field_cnt++;
          if (field_cnt >= 4) begin
            field_cnt = 0;
            if (len_word > {7'd0, maxlen_cfg}) begin
              owe(KIND_STATUS, 8'd0, ST_LEN);
              phase = FR_IDLE;
            end else begin
              phase = (len_word == 0) ? FR_FCS : FR_BODY;
            end
          end
        end
        FR_BODY: begin
          crc_acc = crc_step(crc_acc, b);
          owe(KIND_BYTE, b, ST_OK);
          field_cnt++;
          if (field_cnt >= len_word) begin
            field_cnt = 0;
            phase = FR_FCS;
          end
        end
        FR_FCS: begin
          fcs_word[8*(field_cnt%4) +: 8] = b;
          field_cnt++;
          if (field_cnt >= 4) begin
            field_cnt = 0;
            owe(KIND_STATUS, 8'd0, ((crc_acc ^ CRC_ONES) == fcs_word) ? ST_OK : ST_CRC);
            phase = FR_IDLE;
          end
        end
        default: ;
      endcase
    endfunction

    task report(string what);
      if (errors < 30) $display("[%0t] mismatch: %s", $time, what);
      errors++;
    endtask

    task match_result(cfc_out_t got);
      cfc_out_t want;
      if (awaited.size() == 0) begin
        report($sformatf("result with nothing awaited: %h", got));
        return;
      end
      want = awaited.pop_front();
      if (got.kind !== want.kind)
        report($sformatf("kind %0d, want %0d", got.kind, want.kind));
      if (got.payload_byte !== want.payload_byte)
        report($sformatf("payload_byte %h, want %h", got.payload_byte, want.payload_byte));
      if (got.status !== want.status)
        report($sformatf("status %0d, want %0d", got.status, want.status));
      if (got.seq_number !== want.seq_number)
        report($sformatf("seq_number %h, want %h", got.seq_number, want.seq_number));
      if (got.frame_len !== want.frame_len)
        report($sformatf("frame_len %h, want %h", got.frame_len, want.frame_len));
    endtask
  endclass

  logic                clk = 1'b0;
  logic                rst_n = 1'b0;
  logic                in_valid = 1'b0;
  logic                in_ready;
  cfc_in_t             in_data = '0;
  logic                out_valid;
  logic                out_ready = 1'b0;
  cfc_out_t            out_data;
  logic                psel = 1'b0;
  logic                penable = 1'b0;
  logic                pwrite = 1'b0;
  logic [ADDR_W-1:0]   paddr = '0;
  logic [31:0]         pwdata = '0;
  logic [31:0]         prdata;
  logic                pready;

  frame_tracker sb = new();
  int unsigned cycle_count = 0;
  int unsigned items_sent = 0;
  int in_gap_pct = 0;
  int out_stall_pct = 0;

  crc32_frame_checker DUT (
    .clk, .rst_n,
    .in_valid, .in_ready, .in_data,
    .out_valid, .out_ready, .out_data,
    .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) cycle_count <= cycle_count + 1;

  initial begin
    wait (cycle_count >= CYCLE_LIMIT);
    $display("FAIL crc32_frame_checker");
    $finish;
  end

  // Sample both channels on the edge, before any of this edge's updates land.
  always @(posedge clk) begin
    if (rst_n && in_valid && in_ready) sb.absorb_byte(in_data);
    if (rst_n && out_valid && out_ready) sb.match_result(out_data);
  end

  always begin
    @(posedge clk);
    if (rst_n && out_stall_pct != 0 && $urandom_range(0, 99) < out_stall_pct) begin
      out_ready <= 1'b0;
      repeat ($urandom_range(1, 13)) @(posedge clk);
    end
    out_ready <= 1'b1;
  end

  task automatic send_byte(cfc_in_t d);
    if (in_gap_pct != 0 && $urandom_range(0, 99) < in_gap_pct) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 13)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= d;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    items_sent++;
  endtask

  task automatic send_junk(int n, int start_pct);
    cfc_in_t it;
    for (int i = 0; i < n; i++) begin
      it.rx_byte = 8'($urandom());
      it.frame_start = ($urandom_range(0, 99) < start_pct);
      send_byte(it);
    end
  endtask

  // Build header, body and FCS; spoil one bit at spoil_at, stop after keep bytes.
  task automatic send_frame(logic [31:0] sync_w, logic [15:0] seq, logic [31:0] len_f,
                            int body_n, int spoil_at, int keep);
    logic [7:0]  fb[$];
    logic [31:0] crc;
    cfc_in_t     it;
    int          stop;
    for (int i = 0; i < 4; i++) fb.push_back(sync_w[8*i +: 8]);
    for (int i = 0; i < 2; i++) fb.push_back(seq[8*i +: 8]);
    for (int i = 0; i < 4; i++) fb.push_back(len_f[8*i +: 8]);
    for (int i = 0; i < body_n; i++) fb.push_back(8'($urandom()));
    crc = CRC_ONES;
    foreach (fb[i]) crc = frame_tracker::crc_step(crc, fb[i]);
    crc = crc ^ CRC_ONES;
    for (int i = 0; i < 4; i++) fb.push_back(crc[8*i +: 8]);
    if (spoil_at >= 0 && spoil_at < fb.size())
      fb[spoil_at] = fb[spoil_at] ^ 8'(1 << $urandom_range(0, 7));
    stop = (keep > 0 && keep < fb.size()) ? keep : fb.size();
    for (int i = 0; i < stop; i++) begin
      it.rx_byte = fb[i];
      it.frame_start = (i == 0);
      send_byte(it);
    end
  endtask

  function automatic logic [31:0] good_len();
    logic [31:0] cap;
    cap = ($urandom_range(0, 19) == 0) ? 32'd64 : 32'd12;
    if ({7'd0, sb.maxlen_cfg} < cap) cap = {7'd0, sb.maxlen_cfg};
    return $urandom_range(0, cap);
  endfunction

  function automatic logic [31:0] big_len();
    logic [31:0] lim;
    lim = {7'd0, sb.maxlen_cfg};
    case ($urandom_range(0, 3))
      0: return lim + 1;
      1: return $urandom() | 32'h8000_0000;
      2: return 32'hFFFF_FFFF;
      default: return lim + 1 + $urandom_range(0, 65536);
    endcase
  endfunction

  task automatic random_traffic(int n_items);
    int unsigned first;
    int          pick;
    logic [31:0] len_f;
    logic [31:0] bad_sync;
    first = items_sent;
    while (items_sent - first < n_items) begin
      pick = $urandom_range(0, 99);
      if (pick < 55) begin
        len_f = good_len();
        send_frame(sb.sync_cfg, 16'($urandom()), len_f, len_f, -1, 0);
      end else if (pick < 67) begin
        len_f = good_len();
        send_frame(sb.sync_cfg, 16'($urandom()), len_f, len_f,
                   $urandom_range(10, 13 + len_f), 0);
      end else if (pick < 75) begin
        bad_sync = ($urandom_range(0, 1) == 0) ? sb.sync_cfg ^ (32'd1 << $urandom_range(0, 31))
                                                : $urandom();
        send_frame(bad_sync, 16'($urandom()), $urandom(), 0, -1, $urandom_range(4, 14));
      end else if (pick < 83) begin
        send_frame(sb.sync_cfg, 16'($urandom()), big_len(), $urandom_range(0, 3), -1, 0);
      end else if (pick < 95) begin
        len_f = good_len();
        send_frame(sb.sync_cfg, 16'($urandom()), len_f, len_f, -1,
                   $urandom_range(1, 13 + len_f));
      end else begin
        send_junk($urandom_range(1, 8), 15);
      end
      // trailing bytes after a finished frame are dropped by the block; after a cut frame they continue it
      if ($urandom_range(0, 3) == 0) send_junk($urandom_range(1, 3), 0);
    end
  endtask

  task automatic write_reg(cfc_reg_t r, logic [31:0] v);
    @(posedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= ADDR_W'({r, 2'b00});
    pwdata <= v;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    sb.set_reg(r, v);
  endtask

  task automatic read_back(cfc_reg_t r);
    logic [31:0] got;
    logic [31:0] want;
    logic [31:0] mask;
    @(posedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b0;
    paddr <= ADDR_W'({r, 2'b00});
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    got = prdata;
    psel <= 1'b0;
    penable <= 1'b0;
    want = (r == REG_SYNC) ? sb.sync_cfg : {7'd0, sb.maxlen_cfg};
    mask = (r == REG_SYNC) ? 32'hFFFF_FFFF : {7'd0, {MAXLEN_W{1'b1}}};
    if ((got & mask) !== want)
      sb.report($sformatf("register %s reads %h, want %h", r.name(), got, want));
  endtask

  // Drain owed results, then let bytes that give no result clear the pipeline.
  task automatic settle();
    @(posedge clk);
    while (sb.awaited.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
  endtask

  task automatic run_phase(logic [31:0] sync_v, logic [31:0] maxlen_v, int n_items,
                           int gap_pct, int stall_pct);
    settle();
    write_reg(REG_SYNC, sync_v);
    write_reg(REG_MAXLEN, maxlen_v);
    read_back(REG_SYNC);
    read_back(REG_MAXLEN);
    in_gap_pct = gap_pct;
    out_stall_pct = stall_pct;
    random_traffic(n_items);
    in_valid <= 1'b0;
  endtask

  initial begin
    cfc_in_t idle_byte;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    read_back(REG_SYNC);
    read_back(REG_MAXLEN);
    in_gap_pct = 20;
    out_stall_pct = 20;

    // stray byte with no frame open: dropped
    idle_byte.rx_byte = 8'hFF;
    idle_byte.frame_start = 1'b0;
    send_byte(idle_byte);
    // all-zero sync word: mismatch after four bytes
    send_frame(32'h0, 16'h0, 32'h0, 0, -1, 4);
    // largest length field: over the limit
    send_frame(sb.sync_cfg, 16'hFFFF, 32'hFFFF_FFFF, 0, -1, 10);
    // cut inside the sequence field, the next start truncates it
    send_frame(sb.sync_cfg, 16'h1234, 32'd5, 5, -1, 5);
    // empty body: FCS straight after the header
    send_frame(sb.sync_cfg, 16'h0000, 32'd0, 0, -1, 0);

    random_traffic(300);
    in_valid <= 1'b0;
    run_phase(32'h0000_0000, 32'd0, 320, 25, 25);
    run_phase(32'hFFFF_FFFF, 32'h0100_0000, 320, 10, 40);
    run_phase($urandom(), $urandom_range(0, 24), 320, 40, 10);
    run_phase($urandom(), $urandom_range(0, 32'h0100_0000), 320, 20, 20);
    // final stretch at full rate on both sides
    run_phase($urandom(), $urandom_range(0, 16), 320, 0, 0);

    @(posedge clk);
    while (sb.awaited.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (sb.errors == 0) begin
      $display("PASS crc32_frame_checker");
    end else begin
      $display("FAIL crc32_frame_checker");
    end
    $finish;
  end

endmodule
`default_nettype wire
